/* sv/atilt_pkg.sv */
// shared types, widths and constants for the tilt angle unit
`timescale 1ns / 1ps
package atilt_pkg;

    localparam int VW = 48;
    localparam int ZW = 26;
    localparam int TAB_LEN = 24;
    localparam int SQW = 48;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd5898240;
    localparam logic [40:0] ONE_G_SQ = 41'd1000000;
    localparam int NUM_VEC = 6;
    localparam int NUM_SQRT = 6;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_ang z;
        logic zero;
    } t_cordic;

    function automatic t_ang atan_tab(input int idx);
        t_ang r;
        case (idx)
            0: r = 26'sd2949120;
            1: r = 26'sd1740967;
            2: r = 26'sd919879;
            3: r = 26'sd466945;
            4: r = 26'sd234379;
            5: r = 26'sd117304;
            6: r = 26'sd58666;
            7: r = 26'sd29335;
            8: r = 26'sd14668;
            9: r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* sv/atilt_sqrt_cell.sv */
// one step of the digit-by-digit square root, two radicand bits per cell
`timescale 1ns / 1ps
module atilt_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [atilt_pkg::SQW-1:0]   i_rem,
    input  logic [atilt_pkg::SQW-1:0]   i_root,
    output logic [atilt_pkg::SQW-1:0]   o_rem,
    output logic [atilt_pkg::SQW-1:0]   o_root
);
    import atilt_pkg::*;

    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * STEP);

    logic [SQW-1:0] r_rem, r_root, n_rem, n_root, w_trial;

    always_comb begin
        w_trial = i_root + BIT;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

/* sv/atilt_sqrt_chain.sv */
// pipelined floor square root built from a row of cells
`timescale 1ns / 1ps
module atilt_sqrt_chain (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [atilt_pkg::SQW-1:0]   i_val,
    output logic [atilt_pkg::SQW-1:0]   o_root
);
    import atilt_pkg::*;

    localparam int N = SQW / 2;

    logic [SQW-1:0] w_rem  [N+1];
    logic [SQW-1:0] w_root [N+1];

    assign w_rem[0]  = i_val;
    assign w_root[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        atilt_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_root(w_root[g]),
            .o_rem (w_rem[g+1]),
            .o_root(w_root[g+1])
        );
    end

    assign o_root = w_root[N];
endmodule

/* sv/atilt_cordic_cell.sv */
// one vectoring cordic rotation, registered
`timescale 1ns / 1ps
module atilt_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  atilt_pkg::t_cordic   i_d,
    output atilt_pkg::t_cordic   o_d
);
    import atilt_pkg::*;

    t_cordic r_d, n_d;
    t_vec    w_dx, w_dy;

    always_comb begin
        w_dx = i_d.y >>> STEP;
        w_dy = i_d.x >>> STEP;
        n_d  = i_d;
        if (!i_d.y[VW-1]) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + atan_tab(STEP);
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - atan_tab(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* sv/atilt_cordic_chain.sv */
// atan2 in hundredths of a degree: pre-rotation, a row of cordic cells, rounding
`timescale 1ns / 1ps
module atilt_cordic_chain #(
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  atilt_pkg::t_vec      i_ny,
    input  atilt_pkg::t_vec      i_nx,
    output logic signed [15:0]   o_cdeg
);
    import atilt_pkg::*;

    localparam int N = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

    t_cordic r_pre, n_pre;
    t_cordic w_d [N+1];
    logic signed [ZW+7:0] r_prod;
    logic signed [ZW+7:0] w_rnd;
    logic signed [ZW-9:0] w_q;
    logic signed [15:0]   r_out;

    always_comb begin
        t_vec x, y;
        x = i_nx <<< 8;
        y = i_ny <<< 8;
        n_pre.zero = (i_nx == '0) && (i_ny == '0);
        n_pre.x = x;
        n_pre.y = y;
        n_pre.z = '0;
        if (x[VW-1]) begin
            if (!y[VW-1]) begin
                n_pre.x = y;
                n_pre.y = -x;
                n_pre.z = QUARTER_TURN;
            end else begin
                n_pre.x = -y;
                n_pre.y = x;
                n_pre.z = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    assign w_d[0] = r_pre;

    for (genvar g = 0; g < N; g++) begin : g_cell
        atilt_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_d  (w_d[g]),
            .o_d  (w_d[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_d[N].zero ? '0 : (ZW+8)'(w_d[N].z) * (ZW+8)'(100);
        end
    end

    assign w_rnd = r_prod + (ZW+8)'(32768);
    assign w_q   = w_rnd[ZW+7:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_q > 18000) begin
                r_out <= 16'sd18000;
            end else if (w_q < -18000) begin
                r_out <= -16'sd18000;
            end else begin
                r_out <= 16'(w_q);
            end
        end
    end

    assign o_cdeg = r_out;
endmodule

/* sv/accel_tilt_angles_unit.sv */
// top level: six tilt angles per accelerometer sample from pipelined cordic chains
`timescale 1ns / 1ps
// Accepts one x/y/z sample (milli-g) per cycle and delivers tilt, pitch, roll,
// theta, psi and phi in hundredths of a degree, plus a flag when an asin input
// exceeded one g. Samples pass capture and squares, radicands, the square-root
// cell row (two bits per cell), the cordic pre-rotation and cell row, one
// rotation per cell, and the rounding and output registers. The whole pipeline
// advances whenever the output slot is free or being taken, so samples stream at one per cycle.
module accel_tilt_angles_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // tilt, pitch, roll, theta, psi, phi, asin_clamped
);
    import atilt_pkg::*;

    localparam int SQ_LAT = SQW / 2;
    localparam int N_ST = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int LAT = 2 + SQ_LAT + N_ST + 3 + 1;

    logic w_en;
    logic [LAT-1:0] r_vld;

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: capture and squares
    logic signed [16:0] r_x, r_y, r_z;
    logic [31:0] r_xx, r_yy, r_zz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x  <= 17'(signed'(s_axis_tdata[15:0]));
            r_y  <= 17'(signed'(s_axis_tdata[31:16]));
            r_z  <= 17'(signed'(s_axis_tdata[47:32]));
            r_xx <= 32'($signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[15:0]));
            r_yy <= 32'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]));
            r_zz <= 32'($signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]));
        end
    end

    // stage 2: radicands and clamp decisions
    logic signed [16:0] r2_x, r2_y;
    logic [SQW-1:0] r_rad [NUM_SQRT];
    logic r2_cx, r2_cy, r2_cm;
    logic [32:0] w_m2;
    assign w_m2 = 33'(r_xx) + 33'(r_yy);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x  <= r_x;
            r2_y  <= r_y;
            r2_cx <= r_xx > 32'(ONE_G_SQ);
            r2_cy <= r_yy > 32'(ONE_G_SQ);
            r2_cm <= w_m2 > 33'(ONE_G_SQ);
            r_rad[0] <= SQW'(33'(r_yy) + 33'(r_zz)) << 14;
            r_rad[1] <= SQW'(33'(r_xx) + 33'(r_zz)) << 14;
            r_rad[2] <= SQW'(ONE_G_SQ[31:0] - r_xx) << 14;
            r_rad[3] <= SQW'(ONE_G_SQ[31:0] - r_yy) << 14;
            r_rad[4] <= SQW'(w_m2) << 14;
            r_rad[5] <= SQW'(33'(ONE_G_SQ) - w_m2) << 14;
        end
    end

    logic [SQW-1:0] w_root [NUM_SQRT];
    for (genvar g = 0; g < NUM_SQRT; g++) begin : g_sqrt
        atilt_sqrt_chain u_sqrt (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_val (r_rad[g]),
            .o_root(w_root[g])
        );
    end

    // delay line for operands that bypass the square roots
    logic signed [16:0] r_dx [SQ_LAT];
    logic signed [16:0] r_dy [SQ_LAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx[0] <= r2_x;
            r_dy[0] <= r2_y;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
    end

    // flags ride alongside up to the output
    localparam int FL_LAT = SQ_LAT + N_ST + 3;
    logic [2:0] r_fl [FL_LAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0] <= {r2_cm, r2_cy, r2_cx};
            for (int k = 1; k < FL_LAT; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    t_vec w_ny [NUM_VEC];
    t_vec w_nx [NUM_VEC];
    logic signed [VW-1:0] w_xs, w_ys;
    assign w_xs = VW'(r_dx[SQ_LAT-1]);
    assign w_ys = VW'(r_dy[SQ_LAT-1]);

    assign w_ny[0] = w_xs;              assign w_nx[0] = w_ys;
    assign w_ny[1] = w_xs <<< 7;        assign w_nx[1] = w_root[0];
    assign w_ny[2] = -(w_ys <<< 7);     assign w_nx[2] = w_root[1];
    assign w_ny[3] = w_xs <<< 7;        assign w_nx[3] = w_root[2];
    assign w_ny[4] = w_ys <<< 7;        assign w_nx[4] = w_root[3];
    assign w_ny[5] = w_root[4];         assign w_nx[5] = w_root[5];

    logic signed [15:0] w_ang [NUM_VEC];
    for (genvar g = 0; g < NUM_VEC; g++) begin : g_cordic
        atilt_cordic_chain #(.STEPS(CORDIC_STEPS)) u_cordic (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ny  (w_ny[g]),
            .i_nx  (w_nx[g]),
            .o_cdeg(w_ang[g])
        );
    end

    // sign of asin args travels too
    logic [1:0] r_sg [FL_LAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sg[0] <= {r2_y[16], r2_x[16]};
            for (int k = 1; k < FL_LAT; k++) begin
                r_sg[k] <= r_sg[k-1];
            end
        end
    end

    function automatic logic signed [15:0] clamp90(input logic signed [15:0] v);
        if (v > 16'sd9000) return 16'sd9000;
        if (v < -16'sd9000) return -16'sd9000;
        return v;
    endfunction

    logic [2:0] w_fl;
    logic [1:0] w_sg;
    logic signed [15:0] w_th, w_ps, w_ph, w_pi, w_ro;
    assign w_fl = r_fl[FL_LAT-1];
    assign w_sg = r_sg[FL_LAT-1];
    assign w_pi = clamp90(w_ang[1]);
    assign w_ro = clamp90(w_ang[2]);

    always_comb begin
        w_th = w_fl[0] ? (w_sg[0] ? -16'sd9000 : 16'sd9000) : clamp90(w_ang[3]);
        w_ps = w_fl[1] ? (w_sg[1] ? -16'sd9000 : 16'sd9000) : clamp90(w_ang[4]);
        if (w_fl[2]) begin
            w_ph = 16'sd9000;
        end else if (w_ang[5] < 0) begin
            w_ph = '0;
        end else begin
            w_ph = clamp90(w_ang[5]);
        end
    end

    logic [95:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {5'd0, |w_fl, w_ph[13:0], w_ps[14:0], w_th[14:0],
                      w_ro[14:0], w_pi[14:0], w_ang[0]};
        end
    end

    assign m_axis_tdata = r_out;
endmodule

/* sv/atilt_checker.sv */
// port-level checks for the tilt angle unit, bound to the top level
`timescale 1ns / 1ps
module atilt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");
    a_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 18000 &&
                           $signed(m_axis_tdata[15:0]) >= -18000))
        else $error("tilt out of range");
    a_phi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[89:76] <= 14'd9000)
        else $error("phi out of range");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:91] == 5'd0)
        else $error("padding not zero");
endmodule

bind accel_tilt_angles_unit atilt_checker u_atilt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
